/* hw/rtl/aabb_collision_response_unit_macros.svh */
// Assertion macros shared by the collision response pipeline.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef AABB_COLLISION_RESPONSE_UNIT_MACROS_SVH
`define AABB_COLLISION_RESPONSE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset
`define AABB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aabb collision response check failed");
// Next-cycle implication, disabled during reset
`define AABB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aabb collision response check failed");
`else
`define AABB_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define AABB_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/aabb_cr_pkg.sv */
// Shared types for the box collision response pipeline.
// No dependencies; imported by the overlap and resolve stages.
package aabb_cr_pkg;

   // Per-pair flags carried alongside the arithmetic through the pipe
   typedef struct packed {
      logic dx_neg;
      logic dy_neg;
      logic a_movable;
      logic b_movable;
   } pair_flags_type;

endpackage

/* hw/rtl/aabb_cr_overlap.sv */
// Stages one and two: centre distances, then per-axis overlap.
// Depends on aabb_cr_pkg and the assertion macro header.
`include "aabb_collision_response_unit_macros.svh"

module aabb_cr_overlap import aabb_cr_pkg::*; #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [COORD_WIDTH-1:0]        a_center_x,
   input  logic [COORD_WIDTH-1:0]        a_center_y,
   input  logic [COORD_WIDTH-1:0]        b_center_x,
   input  logic [COORD_WIDTH-1:0]        b_center_y,
   input  logic [COORD_WIDTH-2:0]        sum_width,
   input  logic [COORD_WIDTH-2:0]        sum_height,
   input  logic                          a_movable,
   input  logic                          b_movable,
   input  logic [COORD_WIDTH-1:0]        a_vel_x,
   input  logic [COORD_WIDTH-1:0]        a_vel_y,
   input  logic [COORD_WIDTH-1:0]        b_vel_x,
   input  logic [COORD_WIDTH-1:0]        b_vel_y,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [COORD_WIDTH+1:0] overlap_x,
   output logic signed [COORD_WIDTH+1:0] overlap_y,
   output pair_flags_type                out_flags,
   output logic [COORD_WIDTH-1:0]        out_a_vel_x,
   output logic [COORD_WIDTH-1:0]        out_a_vel_y,
   output logic [COORD_WIDTH-1:0]        out_b_vel_x,
   output logic [COORD_WIDTH-1:0]        out_b_vel_y
);

   localparam int C = COORD_WIDTH;

   logic                 s1_adv;
   logic                 s2_adv;
   logic                 s1_valid_ff, s1_valid_in;
   logic signed [C:0]    s1_dx_ff, s1_dx_in;
   logic signed [C:0]    s1_dy_ff, s1_dy_in;
   logic [C-3:0]         s1_halfw_ff, s1_halfh_ff;
   pair_flags_type       s1_flags_ff;
   logic [C-1:0]         s1_avx_ff, s1_avy_ff, s1_bvx_ff, s1_bvy_ff;
   logic [C:0]           abs_dx, abs_dy;
   logic                 s2_valid_ff, s2_valid_in;
   logic signed [C+1:0]  s2_ox_ff, s2_ox_in;
   logic signed [C+1:0]  s2_oy_ff, s2_oy_in;
   pair_flags_type       s2_flags_ff, s2_flags_in;
   logic [C-1:0]         s2_avx_ff, s2_avy_ff, s2_bvx_ff, s2_bvy_ff;

   // Advance a stage when it is empty or the next one takes its word
   assign s2_adv   = !s2_valid_ff || out_ready;
   assign s1_adv   = !s1_valid_ff || s2_adv;
   assign in_ready = s1_adv;

   // Stage one: exact centre differences, one bit wider than the centres
   always_comb begin
      s1_valid_in = s1_adv ? in_valid : s1_valid_ff;
      s1_dx_in    = $signed({b_center_x[C-1], b_center_x})
                  - $signed({a_center_x[C-1], a_center_x});
      s1_dy_in    = $signed({b_center_y[C-1], b_center_y})
                  - $signed({a_center_y[C-1], a_center_y});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_dx_ff              <= s1_dx_in;
         s1_dy_ff              <= s1_dy_in;
         s1_halfw_ff           <= sum_width[C-2:1];
         s1_halfh_ff           <= sum_height[C-2:1];
         s1_flags_ff.dx_neg    <= 1'b0;
         s1_flags_ff.dy_neg    <= 1'b0;
         s1_flags_ff.a_movable <= a_movable;
         s1_flags_ff.b_movable <= b_movable;
         s1_avx_ff             <= a_vel_x;
         s1_avy_ff             <= a_vel_y;
         s1_bvx_ff             <= b_vel_x;
         s1_bvy_ff             <= b_vel_y;
      end
   end

   // Stage two: overlap is half the summed size less the absolute distance
   always_comb begin
      abs_dx      = s1_dx_ff[C] ? (~s1_dx_ff + 1'b1) : s1_dx_ff;
      abs_dy      = s1_dy_ff[C] ? (~s1_dy_ff + 1'b1) : s1_dy_ff;
      s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;
      s2_ox_in    = $signed({4'b0000, s1_halfw_ff}) - $signed({1'b0, abs_dx});
      s2_oy_in    = $signed({4'b0000, s1_halfh_ff}) - $signed({1'b0, abs_dy});
      s2_flags_in        = s1_flags_ff;
      s2_flags_in.dx_neg = s1_dx_ff[C];
      s2_flags_in.dy_neg = s1_dy_ff[C];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s2_ox_ff    <= s2_ox_in;
         s2_oy_ff    <= s2_oy_in;
         s2_flags_ff <= s2_flags_in;
         s2_avx_ff   <= s1_avx_ff;
         s2_avy_ff   <= s1_avy_ff;
         s2_bvx_ff   <= s1_bvx_ff;
         s2_bvy_ff   <= s1_bvy_ff;
      end
   end

   assign out_valid   = s2_valid_ff;
   assign overlap_x   = s2_ox_ff;
   assign overlap_y   = s2_oy_ff;
   assign out_flags   = s2_flags_ff;
   assign out_a_vel_x = s2_avx_ff;
   assign out_a_vel_y = s2_avy_ff;
   assign out_b_vel_x = s2_bvx_ff;
   assign out_b_vel_y = s2_bvy_ff;

   // A word in stage one moves on whenever stage two makes room
   `AABB_ASSERT_NEXT(a_s1_moves_on, clock, reset, s1_valid_ff && s2_adv, s2_valid_ff)
   // A positive overlap stays below a quarter of the coordinate range
   `AABB_ASSERT_IMP(a_overlap_bound, clock, reset, s2_valid_ff && !s2_ox_ff[C+1],
                    s2_ox_ff[C+1:C-2] == 4'b0000)

endmodule

/* hw/rtl/aabb_cr_resolve.sv */
// Stage three: pick the push axis, share the push and clip velocities.
// Depends on aabb_cr_pkg and the assertion macro header.
`include "aabb_collision_response_unit_macros.svh"

module aabb_cr_resolve import aabb_cr_pkg::*; #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH+1:0] overlap_x,
   input  logic signed [COORD_WIDTH+1:0] overlap_y,
   input  pair_flags_type                in_flags,
   input  logic [COORD_WIDTH-1:0]        a_vel_x,
   input  logic [COORD_WIDTH-1:0]        a_vel_y,
   input  logic [COORD_WIDTH-1:0]        b_vel_x,
   input  logic [COORD_WIDTH-1:0]        b_vel_y,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic                          contact,
   output logic [COORD_WIDTH-2:0]        a_shift_x,
   output logic [COORD_WIDTH-2:0]        a_shift_y,
   output logic [COORD_WIDTH-2:0]        b_shift_x,
   output logic [COORD_WIDTH-2:0]        b_shift_y,
   output logic [COORD_WIDTH-1:0]        a_new_vel_x,
   output logic [COORD_WIDTH-1:0]        a_new_vel_y,
   output logic [COORD_WIDTH-1:0]        b_new_vel_x,
   output logic [COORD_WIDTH-1:0]        b_new_vel_y
);

   localparam int C = COORD_WIDTH;

   logic           adv;
   logic           valid_ff, valid_in;
   logic           pos_x, pos_y, use_x, d_neg, hit, a_push, b_push;
   logic [C-3:0]   ov, part;
   logic [C-2:0]   part_pos, part_neg, a_shift, b_shift;
   logic           a_zero_v, b_zero_v;
   logic [C-1:0]   a_vel, b_vel;
   logic           contact_ff, contact_in;
   logic [C-2:0]   ashx_ff, ashx_in, ashy_ff, ashy_in;
   logic [C-2:0]   bshx_ff, bshx_in, bshy_ff, bshy_in;
   logic [C-1:0]   avx_ff, avx_in, avy_ff, avy_in;
   logic [C-1:0]   bvx_ff, bvx_in, bvy_ff, bvy_in;

   // Take a new word when the output register is empty or being drained
   assign adv      = !valid_ff || out_ready;
   assign in_ready = adv;

   // Choose the axis of smaller overlap; a tie goes to Y
   always_comb begin
      pos_x    = !overlap_x[C+1] && (overlap_x != '0);
      pos_y    = !overlap_y[C+1] && (overlap_y != '0);
      hit      = pos_x && pos_y && (in_flags.a_movable || in_flags.b_movable);
      use_x    = overlap_x < overlap_y;
      ov       = use_x ? overlap_x[C-3:0] : overlap_y[C-3:0];
      d_neg    = use_x ? in_flags.dx_neg : in_flags.dy_neg;
      part     = (in_flags.a_movable && in_flags.b_movable) ? {1'b0, ov[C-3:1]} : ov;
      part_pos = {1'b0, part};
      part_neg = ~part_pos + 1'b1;
      // A moves against the B direction, B moves along it
      a_shift  = d_neg ? part_pos : part_neg;
      b_shift  = d_neg ? part_neg : part_pos;
      a_push   = hit && in_flags.a_movable;
      b_push   = hit && in_flags.b_movable;
      a_vel    = use_x ? a_vel_x : a_vel_y;
      b_vel    = use_x ? b_vel_x : b_vel_y;
      // Drop velocity that points into the partner
      a_zero_v = d_neg ? a_vel[C-1] : (!a_vel[C-1] && (a_vel != '0));
      b_zero_v = d_neg ? (!b_vel[C-1] && (b_vel != '0)) : b_vel[C-1];
   end

   always_comb begin
      valid_in   = adv ? in_valid : valid_ff;
      contact_in = hit;
      ashx_in    = (a_push && use_x)  ? a_shift : '0;
      ashy_in    = (a_push && !use_x) ? a_shift : '0;
      bshx_in    = (b_push && use_x)  ? b_shift : '0;
      bshy_in    = (b_push && !use_x) ? b_shift : '0;
      avx_in     = (a_push && use_x  && a_zero_v) ? '0 : a_vel_x;
      avy_in     = (a_push && !use_x && a_zero_v) ? '0 : a_vel_y;
      bvx_in     = (b_push && use_x  && b_zero_v) ? '0 : b_vel_x;
      bvy_in     = (b_push && !use_x && b_zero_v) ? '0 : b_vel_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the result word until it is taken
   always_ff @(posedge clock) begin
      if (adv) begin
         contact_ff <= contact_in;
         ashx_ff    <= ashx_in;
         ashy_ff    <= ashy_in;
         bshx_ff    <= bshx_in;
         bshy_ff    <= bshy_in;
         avx_ff     <= avx_in;
         avy_ff     <= avy_in;
         bvx_ff     <= bvx_in;
         bvy_ff     <= bvy_in;
      end
   end

   assign out_valid   = valid_ff;
   assign contact     = contact_ff;
   assign a_shift_x   = ashx_ff;
   assign a_shift_y   = ashy_ff;
   assign b_shift_x   = bshx_ff;
   assign b_shift_y   = bshy_ff;
   assign a_new_vel_x = avx_ff;
   assign a_new_vel_y = avy_ff;
   assign b_new_vel_x = bvx_ff;
   assign b_new_vel_y = bvy_ff;

   // Without contact no box is moved
   `AABB_ASSERT_IMP(a_no_contact_no_shift, clock, reset, valid_ff && !contact_ff,
                    ashx_ff == '0 && ashy_ff == '0 && bshx_ff == '0 && bshy_ff == '0)
   // Only one axis is ever pushed
   `AABB_ASSERT_IMP(a_single_axis, clock, reset, valid_ff,
                    (ashx_ff == '0 || ashy_ff == '0) && (bshx_ff == '0 || bshy_ff == '0))
   // Two moving boxes are pushed apart by equal and opposite amounts
   `AABB_ASSERT_IMP(a_opposite_shift, clock, reset, valid_ff,
                    ashx_ff == '0 || bshx_ff == '0 || ashx_ff == (~bshx_ff + 1'b1))

endmodule

/* hw/rtl/aabb_collision_response_unit.sv */
// Box collision response: three register stages; a req word moves through stage one
// and stage two into the resolve output register, which raises rsp_tvalid. Throughput one
// pair per cycle unless stalled; each stage stalls only when full, so bubbles close up and
// rsp_tready back-pressure reaches req_tready combinationally, in the same cycle.
// Synchronous active-high reset clears the stage valid bits; payload is not reset.
// Depends on aabb_cr_overlap and aabb_cr_resolve.
module aabb_collision_response_unit import aabb_cr_pkg::*; #(
   parameter int COORD_WIDTH = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // req_tdata from bit 0: a_center_x, a_center_y, b_center_x, b_center_y,
   // sum_width, sum_height, a_movable, b_movable, a_vel_x, a_vel_y, b_vel_x,
   // b_vel_y, zero padding to whole bytes
   input  logic [((10*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // rsp_tdata from bit 0: contact, a_shift_x, a_shift_y, b_shift_x, b_shift_y,
   // a_new_vel_x, a_new_vel_y, b_new_vel_x, b_new_vel_y, zero padding
   output logic [((8*COORD_WIDTH-3+7)/8)*8-1:0] rsp_tdata
);

   localparam int C       = COORD_WIDTH;
   localparam int OffAx   = 0;
   localparam int OffAy   = C;
   localparam int OffBx   = 2*C;
   localparam int OffBy   = 3*C;
   localparam int OffSw   = 4*C;
   localparam int OffSh   = 5*C-1;
   localparam int OffAm   = 6*C-2;
   localparam int OffBm   = 6*C-1;
   localparam int OffAvx  = 6*C;
   localparam int OffAvy  = 7*C;
   localparam int OffBvx  = 8*C;
   localparam int OffBvy  = 9*C;
   localparam int OutBits = 8*C-3;
   localparam int OutW    = ((OutBits+7)/8)*8;
   localparam int OutPad  = OutW-OutBits;

   logic                mid_valid, mid_ready;
   logic signed [C+1:0] mid_ox, mid_oy;
   pair_flags_type      mid_flags;
   logic [C-1:0]        mid_avx, mid_avy, mid_bvx, mid_bvy;
   logic                contact;
   logic [C-2:0]        a_shift_x, a_shift_y, b_shift_x, b_shift_y;
   logic [C-1:0]        a_new_vel_x, a_new_vel_y, b_new_vel_x, b_new_vel_y;

   // Distances and overlaps
   aabb_cr_overlap #(.COORD_WIDTH(COORD_WIDTH)) u_overlap (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .a_center_x  (req_tdata[OffAx +: C]),
      .a_center_y  (req_tdata[OffAy +: C]),
      .b_center_x  (req_tdata[OffBx +: C]),
      .b_center_y  (req_tdata[OffBy +: C]),
      .sum_width   (req_tdata[OffSw +: C-1]),
      .sum_height  (req_tdata[OffSh +: C-1]),
      .a_movable   (req_tdata[OffAm]),
      .b_movable   (req_tdata[OffBm]),
      .a_vel_x     (req_tdata[OffAvx +: C]),
      .a_vel_y     (req_tdata[OffAvy +: C]),
      .b_vel_x     (req_tdata[OffBvx +: C]),
      .b_vel_y     (req_tdata[OffBvy +: C]),
      .out_valid   (mid_valid),
      .out_ready   (mid_ready),
      .overlap_x   (mid_ox),
      .overlap_y   (mid_oy),
      .out_flags   (mid_flags),
      .out_a_vel_x (mid_avx),
      .out_a_vel_y (mid_avy),
      .out_b_vel_x (mid_bvx),
      .out_b_vel_y (mid_bvy)
   );

   // Axis choice, push shares and velocity clipping
   aabb_cr_resolve #(.COORD_WIDTH(COORD_WIDTH)) u_resolve (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (mid_valid),
      .in_ready    (mid_ready),
      .overlap_x   (mid_ox),
      .overlap_y   (mid_oy),
      .in_flags    (mid_flags),
      .a_vel_x     (mid_avx),
      .a_vel_y     (mid_avy),
      .b_vel_x     (mid_bvx),
      .b_vel_y     (mid_bvy),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .contact     (contact),
      .a_shift_x   (a_shift_x),
      .a_shift_y   (a_shift_y),
      .b_shift_x   (b_shift_x),
      .b_shift_y   (b_shift_y),
      .a_new_vel_x (a_new_vel_x),
      .a_new_vel_y (a_new_vel_y),
      .b_new_vel_x (b_new_vel_x),
      .b_new_vel_y (b_new_vel_y)
   );

   // Pack the result word, first field lowest
   assign rsp_tdata = {{OutPad{1'b0}}, b_new_vel_y, b_new_vel_x, a_new_vel_y, a_new_vel_x,
                       b_shift_y, b_shift_x, a_shift_y, a_shift_x, contact};

endmodule
